/* src/bclr_pkg.sv */
// Shared types and constants for the button click / long press / repeat block.
// No dependencies; every other file in src uses this package.
package bclr_pkg;

  localparam int unsigned NumButtons = 3;
  localparam int unsigned NowW       = 32;
  localparam int unsigned CfgW       = 16;
  localparam int unsigned CfgIdxW    = 8;

  // Button slots in the per-button state arrays.
  localparam int unsigned BtnUp   = 0;
  localparam int unsigned BtnDown = 1;
  localparam int unsigned BtnSel  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegMinClick       = 8'd0,
    RegLongPress      = 8'd1,
    RegRepeatDelay    = 8'd2,
    RegRepeatInterval = 8'd3
  } cfg_reg_e;

  localparam logic [CfgW-1:0] MinClickRst       = 16'd50;
  localparam logic [CfgW-1:0] LongPressRst      = 16'd800;
  localparam logic [CfgW-1:0] RepeatDelayRst    = 16'd300;
  localparam logic [CfgW-1:0] RepeatIntervalRst = 16'd150;

  typedef struct packed {
    logic            up_level;
    logic            down_level;
    logic            select_level;
    logic [NowW-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic up_event;
    logic down_event;
    logic select_event;
    logic back_event;
  } out_item_t;

endpackage

/* src/bclr_in_if.sv */
// Poll item channel: valid/ready handshake carrying button levels and time.
// Depends on bclr_pkg.
interface bclr_in_if;
  logic               valid;
  logic               ready;
  bclr_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/bclr_out_if.sv */
// Result item channel: valid/ready handshake carrying the four event flags.
// Depends on bclr_pkg.
interface bclr_out_if;
  logic                valid;
  logic                ready;
  bclr_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/bclr_cfg_if.sv */
// Configuration write channel: valid/ready with register index and data.
// Depends on bclr_pkg.
interface bclr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bclr_pkg::CfgIdxW-1:0]     index;
  logic [bclr_pkg::CfgW-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/button_click_longpress_repeat.sv */
// Top level: three-button poller with click, long press and auto-repeat events.
// Depends on bclr_pkg, bclr_in_if, bclr_out_if, bclr_cfg_if.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   up/down/select level (active low), now_ms[31:0]
//   out_o    out  valid/ready   up/down/select/back event flags
//   cfg_i    in   valid/ready   index[7:0], data[15:0] (always ready)
//
// One item per cycle sustained while out_o is not stalled. An item is held in the
// input register and its result is registered in the output register. The
// per-button state updates as the item moves from the input register to the
// output register, so consecutive items see each other's effects in order.
// Reset clears the handshake, the button flags and loads the default thresholds.
// A stall on out_o holds the result; in_i stays ready while the input register
// can still drain, so one item waits in each register at most.
module button_click_longpress_repeat (
  input  logic       clk_i,
  input  logic       rst_ni,
  bclr_in_if.sink    in_i,
  bclr_out_if.source out_o,
  bclr_cfg_if.sink   cfg_i
);

  localparam int unsigned Nb = bclr_pkg::NumButtons;
  localparam int unsigned Tw = bclr_pkg::NowW;

  // Configuration registers.
  logic [bclr_pkg::CfgW-1:0] min_click_q, long_press_q, rep_delay_q, rep_int_q;

  // Input register.
  logic               s1_valid_q;
  bclr_pkg::in_item_t s1_data_q;

  // Output register.
  logic                out_valid_q;
  bclr_pkg::out_item_t out_data_q, out_data_d;

  // Per-button state.
  logic [Nb-1:0]         held_q, held_d;
  logic [Nb-1:0]         long_q, long_d;
  logic [Nb-1:0][Tw-1:0] start_q, start_d;
  logic [Nb-1:0][Tw-1:0] last_q, last_d;

  logic out_load, s1_adv, in_ready;

  // Output register can take a new result when empty or being drained.
  assign out_load = !out_valid_q || out_o.ready;
  assign s1_adv   = s1_valid_q && out_load;
  assign in_ready = !s1_valid_q || s1_adv;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Config writes; unknown index is dropped, data is 16 bits already.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_click_q  <= bclr_pkg::MinClickRst;
      long_press_q <= bclr_pkg::LongPressRst;
      rep_delay_q  <= bclr_pkg::RepeatDelayRst;
      rep_int_q    <= bclr_pkg::RepeatIntervalRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        bclr_pkg::RegMinClick:       min_click_q  <= cfg_i.data;
        bclr_pkg::RegLongPress:      long_press_q <= cfg_i.data;
        bclr_pkg::RegRepeatDelay:    rep_delay_q  <= cfg_i.data;
        bclr_pkg::RegRepeatInterval: rep_int_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Event decode: three independent per-button updates off the input register.
  always_comb begin
    logic [Tw-1:0] now_t;
    logic [Tw-1:0] dur;
    logic [Tw-1:0] since_rep;
    logic [Nb-1:0] pressed;
    logic [Nb-1:0] ev;
    logic          back;

    now_t     = s1_data_q.now_ms;
    pressed   = ~{s1_data_q.select_level, s1_data_q.down_level, s1_data_q.up_level};
    ev        = '0;
    back      = 1'b0;
    dur       = '0;
    since_rep = '0;
    held_d    = held_q;
    long_d    = long_q;
    start_d   = start_q;
    last_d    = last_q;

    for (int b = 0; b < Nb; b++) begin
      // Wrapping differences against the stored press and repeat times.
      dur       = now_t - start_q[b];
      since_rep = now_t - last_q[b];
      if (pressed[b] != held_q[b]) begin
        if (pressed[b]) begin
          // Press edge: record start time, no event.
          held_d[b]  = 1'b1;
          start_d[b] = now_t;
          last_d[b]  = now_t;
          long_d[b]  = 1'b0;
        end else begin
          // Release: click if held at least the minimum click time, unless a long press already fired.
          ev[b]     = !long_q[b] && (dur >= Tw'(min_click_q));
          held_d[b] = 1'b0;
          long_d[b] = 1'b0;
        end
      end else if (pressed[b]) begin
        if (b == bclr_pkg::BtnSel) begin
          if (!long_q[b] && (dur >= Tw'(long_press_q))) begin
            long_d[b] = 1'b1;
            back      = 1'b1;
          end
        end else if ((dur >= Tw'(rep_delay_q)) &&
                     (since_rep >= Tw'(rep_int_q))) begin
          last_d[b] = now_t;
          ev[b]     = 1'b1;
        end
      end
    end

    out_data_d.up_event     = ev[bclr_pkg::BtnUp];
    out_data_d.down_event   = ev[bclr_pkg::BtnDown];
    out_data_d.select_event = ev[bclr_pkg::BtnSel];
    out_data_d.back_event   = back;
  end

  // Handshake and button flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      held_q      <= '0;
      long_q      <= '0;
      start_q     <= '0;
      last_q      <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        held_q  <= held_d;
        long_q  <= long_d;
        start_q <= start_d;
        last_q  <= last_d;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_data_q <= in_i.data;
    end
    if (s1_adv) begin
      out_data_q <= out_data_d;
    end
  end

  // Up and down never mark a long press.
  a_no_long_updown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !long_q[bclr_pkg::BtnUp] && !long_q[bclr_pkg::BtnDown])
    else $error("long press flag set on up or down");

  // A back event leaves select marked as long-fired.
  a_back_sets_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && out_data_d.back_event) |=> long_q[bclr_pkg::BtnSel])
    else $error("back event without long-fired flag");

  // Select click and back event cannot come from the same poll.
  a_sel_back_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q.select_event && out_data_q.back_event))
    else $error("select click together with back event");

  // An empty output register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

/* bench/tb.sv */
// Self-checking bench for the three-button click / long press / auto-repeat poller.
// Depends on bclr_pkg, the three channel interfaces and button_click_longpress_repeat.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned NumCfgRegs  = 4;
  localparam int unsigned DrainCycles = 4;     // settle time after the last result
  localparam int unsigned StallLimit  = 2000;  // cycles with no handshake at all
  localparam int unsigned PhaseItems  = 225;   // six phases, about 1350 polls

  // Predicts the four event flags of each poll and keeps them until the block
  // delivers its result; keeps its own copy of thresholds and per-button state.
  class button_event_sb;
    logic [bclr_pkg::CfgW-1:0] min_click;
    logic [bclr_pkg::CfgW-1:0] long_press;
    logic [bclr_pkg::CfgW-1:0] rep_delay;
    logic [bclr_pkg::CfgW-1:0] rep_interval;
    bit                        held      [bclr_pkg::NumButtons];
    bit                        fired     [bclr_pkg::NumButtons];
    logic [bclr_pkg::NowW-1:0] start_ms  [bclr_pkg::NumButtons];
    logic [bclr_pkg::NowW-1:0] last_rep  [bclr_pkg::NumButtons];
    bclr_pkg::out_item_t       pending_events[$];
    int unsigned               mismatches;

    function new();
      min_click    = bclr_pkg::MinClickRst;
      long_press   = bclr_pkg::LongPressRst;
      rep_delay    = bclr_pkg::RepeatDelayRst;
      rep_interval = bclr_pkg::RepeatIntervalRst;
      for (int b = 0; b < bclr_pkg::NumButtons; b++) begin
        held[b]     = 1'b0;
        fired[b]    = 1'b0;
        start_ms[b] = '0;
        last_rep[b] = '0;
      end
      mismatches = 0;
    endfunction

    // Unknown indexes leave every threshold alone.
    function void write_reg(logic [bclr_pkg::CfgIdxW-1:0] idx,
                            logic [bclr_pkg::CfgW-1:0] val);
      case (idx)
        bclr_pkg::RegMinClick:       min_click    = val;
        bclr_pkg::RegLongPress:      long_press   = val;
        bclr_pkg::RegRepeatDelay:    rep_delay    = val;
        bclr_pkg::RegRepeatInterval: rep_interval = val;
        default: ;
      endcase
    endfunction

    function void note_poll(bclr_pkg::in_item_t it);
      logic [bclr_pkg::NumButtons-1:0] pressed;
      logic [bclr_pkg::NowW-1:0]       dur;
      logic [bclr_pkg::NowW-1:0]       since;
      bit                              ev [bclr_pkg::NumButtons];
      bit                              back;
      bclr_pkg::out_item_t             res;
      pressed[bclr_pkg::BtnUp]   = ~it.up_level;
      pressed[bclr_pkg::BtnDown] = ~it.down_level;
      pressed[bclr_pkg::BtnSel]  = ~it.select_level;
      back = 1'b0;
      for (int b = 0; b < bclr_pkg::NumButtons; b++) begin
        ev[b] = 1'b0;
        dur   = it.now_ms - start_ms[b];
        since = it.now_ms - last_rep[b];
        if (pressed[b] != held[b]) begin
          if (pressed[b]) begin
            held[b]     = 1'b1;
            start_ms[b] = it.now_ms;
            last_rep[b] = it.now_ms;
            fired[b]    = 1'b0;
          end else begin
            if (!fired[b] && dur >= bclr_pkg::NowW'(min_click)) ev[b] = 1'b1;
            held[b]  = 1'b0;
            fired[b] = 1'b0;
          end
        end else if (pressed[b]) begin
          if (b == bclr_pkg::BtnSel) begin
            if (!fired[b] && dur >= bclr_pkg::NowW'(long_press)) begin
              fired[b] = 1'b1;
              back     = 1'b1;
            end
          end else if (dur >= bclr_pkg::NowW'(rep_delay) &&
                       since >= bclr_pkg::NowW'(rep_interval)) begin
            last_rep[b] = it.now_ms;
            ev[b]       = 1'b1;
          end
        end
      end
      res.up_event     = ev[bclr_pkg::BtnUp];
      res.down_event   = ev[bclr_pkg::BtnDown];
      res.select_event = ev[bclr_pkg::BtnSel];
      res.back_event   = back;
      pending_events.push_back(res);
    endfunction

    function void check_events(bclr_pkg::out_item_t got);
      bclr_pkg::out_item_t exp;
      if (pending_events.size() == 0) begin
        $error("unexpected result item %b with no poll outstanding", got);
        mismatches++;
        return;
      end
      exp = pending_events.pop_front();
      if (got.up_event !== exp.up_event) begin
        $error("up_event: expected %0b, actual %0b", exp.up_event, got.up_event);
        mismatches++;
      end
      if (got.down_event !== exp.down_event) begin
        $error("down_event: expected %0b, actual %0b", exp.down_event, got.down_event);
        mismatches++;
      end
      if (got.select_event !== exp.select_event) begin
        $error("select_event: expected %0b, actual %0b", exp.select_event, got.select_event);
        mismatches++;
      end
      if (got.back_event !== exp.back_event) begin
        $error("back_event: expected %0b, actual %0b", exp.back_event, got.back_event);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_events.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bclr_in_if  in_if ();
  bclr_out_if out_if ();
  bclr_cfg_if cfg_if ();

  button_click_longpress_repeat u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  button_event_sb sb = new();

  int unsigned                     send_idle_pct;
  int unsigned                     recv_idle_pct;
  logic [bclr_pkg::NowW-1:0]       clock_ms;    // running poll timestamp
  logic [bclr_pkg::NumButtons-1:0] pins;        // current pin levels, 1 = released
  int unsigned                     span;        // typical time step, follows the thresholds

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Stall the result channel at random; the rate changes with the phase.
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watch all three channels: feed accepted polls and register writes to the
  // predictor, and check each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) sb.note_poll(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_events(out_if.data);
    end
  end

  // End the run when no channel moves an item for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Build a poll item from a mask of pressed buttons (bit BtnUp, BtnDown, BtnSel).
  function automatic bclr_pkg::in_item_t poll_of(logic [bclr_pkg::NumButtons-1:0] pressed,
                                                 logic [bclr_pkg::NowW-1:0] now);
    bclr_pkg::in_item_t it;
    it.up_level     = ~pressed[bclr_pkg::BtnUp];
    it.down_level   = ~pressed[bclr_pkg::BtnDown];
    it.select_level = ~pressed[bclr_pkg::BtnSel];
    it.now_ms       = now;
    return it;
  endfunction

  // Offer one poll item, idling first at random; returns at the edge that takes it.
  // Valid is left high so the next call can follow without a gap.
  task automatic send_poll(bclr_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Stop offering polls, wait for every predicted result, then let the pipe settle.
  // Step one edge first so the last accepted poll is already noted.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write all four thresholds plus one write to an unused index that must be dropped.
  task automatic set_thresholds(logic [bclr_pkg::CfgW-1:0] min_c,
                                logic [bclr_pkg::CfgW-1:0] long_p,
                                logic [bclr_pkg::CfgW-1:0] delay,
                                logic [bclr_pkg::CfgW-1:0] interval);
    logic [bclr_pkg::CfgIdxW-1:0] idx [5];
    logic [bclr_pkg::CfgW-1:0]    val [5];
    idx[0] = bclr_pkg::RegMinClick;       val[0] = min_c;
    idx[1] = bclr_pkg::RegLongPress;      val[1] = long_p;
    idx[2] = bclr_pkg::CfgIdxW'($urandom_range(255, NumCfgRegs));
    val[2] = bclr_pkg::CfgW'($urandom());
    idx[3] = bclr_pkg::RegRepeatDelay;    val[3] = delay;
    idx[4] = bclr_pkg::RegRepeatInterval; val[4] = interval;
    for (int k = 0; k < 5; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[k];
      cfg_if.data  <= val[k];
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
    // Scale time steps so holds land on both sides of the largest threshold.
    span = 4;
    if (long_p > span) span = long_p;
    if (delay > span) span = delay;
    if (min_c > span) span = min_c;
    if (interval > span) span = interval;
    span = span / 3 + 4;
  endtask

  // Next random poll: mostly presses and holds with plausible time steps,
  // with tiny steps, long gaps, backward steps and pure noise mixed in.
  task automatic next_random_poll(output bclr_pkg::in_item_t it);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) begin
      pins     = bclr_pkg::NumButtons'($urandom_range(7));
      clock_ms = $urandom();
    end else begin
      for (int b = 0; b < bclr_pkg::NumButtons; b++)
        if ($urandom_range(99) < 20) pins[b] = ~pins[b];
      roll = $urandom_range(99);
      if (roll < 60)      clock_ms = clock_ms + $urandom_range(span);
      else if (roll < 80) clock_ms = clock_ms + $urandom_range(3);
      else if (roll < 95) clock_ms = clock_ms + $urandom_range(3 * span, span);
      else                clock_ms = clock_ms - $urandom_range(100, 1);
    end
    it.up_level     = pins[bclr_pkg::BtnUp];
    it.down_level   = pins[bclr_pkg::BtnDown];
    it.select_level = pins[bclr_pkg::BtnSel];
    it.now_ms       = clock_ms;
  endtask

  initial begin
    bclr_pkg::in_item_t it;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    out_if.ready  = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 53;
    pins          = '1;
    clock_ms      = '0;
    span          = 270;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed polls against the reset thresholds (50 / 800 / 300 / 150).
    send_poll(poll_of(3'b000, 32'd0));
    // Click just below and exactly at the minimum hold.
    send_poll(poll_of(3'b001, 32'd100));
    send_poll(poll_of(3'b000, 32'd149));
    send_poll(poll_of(3'b001, 32'd200));
    send_poll(poll_of(3'b000, 32'd250));
    // Long press of select: one back event, no click on release.
    send_poll(poll_of(3'b100, 32'd1000));
    send_poll(poll_of(3'b100, 32'd1799));
    send_poll(poll_of(3'b100, 32'd1800));
    send_poll(poll_of(3'b100, 32'd5000));
    send_poll(poll_of(3'b000, 32'd5001));
    // Auto-repeat on down at the delay, one short of and at the interval, then
    // release during repeats still clicks.
    send_poll(poll_of(3'b010, 32'd6000));
    send_poll(poll_of(3'b010, 32'd6300));
    send_poll(poll_of(3'b010, 32'd6449));
    send_poll(poll_of(3'b010, 32'd6450));
    send_poll(poll_of(3'b000, 32'd6460));
    // Hold across the timestamp wrap.
    send_poll(poll_of(3'b111, 32'hFFFF_FFF0));
    send_poll(poll_of(3'b111, 32'h0000_0010));
    send_poll(poll_of(3'b000, 32'h0000_0030));
    // Time stepping backwards looks like a very long hold.
    send_poll(poll_of(3'b100, 32'h0000_1000));
    send_poll(poll_of(3'b100, 32'h0000_0FFF));
    send_poll(poll_of(3'b101, 32'h0000_2000));
    send_poll(poll_of(3'b101, 32'h0000_1FFF));
    send_poll(poll_of(3'b000, 32'h0000_2000));
    // Press and release at the same instant, at the top of the time range.
    send_poll(poll_of(3'b111, 32'hFFFF_FFFF));
    send_poll(poll_of(3'b000, 32'hFFFF_FFFF));
    drain();
    clock_ms = 32'h0000_2000;
    pins     = '1;

    // Random phases: each gets its own thresholds, idling shifts every two phases.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin send_idle_pct = 34; recv_idle_pct = 53; end
        1: begin send_idle_pct = 53; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (phase)
        0: set_thresholds(bclr_pkg::MinClickRst, bclr_pkg::LongPressRst,
                          bclr_pkg::RepeatDelayRst, bclr_pkg::RepeatIntervalRst);
        1: set_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
        2: set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: set_thresholds(bclr_pkg::CfgW'($urandom_range(200)),
                          bclr_pkg::CfgW'($urandom_range(200)),
                          bclr_pkg::CfgW'($urandom_range(200)),
                          bclr_pkg::CfgW'($urandom_range(200)));
        4: set_thresholds(bclr_pkg::CfgW'($urandom()), bclr_pkg::CfgW'($urandom()),
                          bclr_pkg::CfgW'($urandom()), bclr_pkg::CfgW'($urandom()));
        default: set_thresholds(16'd0, 16'hFFFF, 16'd1, 16'd0);
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        next_random_poll(it);
        send_poll(it);
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* button_click_longpress_repeat.f */
src/bclr_pkg.sv
src/bclr_in_if.sv
src/bclr_out_if.sv
src/bclr_cfg_if.sv
src/button_click_longpress_repeat.sv
bench/tb.sv
